### rtl/fdca_pkg.sv
// ----------------------------------------------------------------------------
// fdca_pkg
// shared codes and types of the file directory allocator
// ----------------------------------------------------------------------------
package fdca_pkg;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_CREATE = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_NO_ENTRY  = 3'd3;
	localparam logic [2:0] ST_DISK_FULL = 3'd4;

	localparam int NAME_W = 64;
	localparam int LEN_W  = 8;
	localparam int OUT_START_W = 9;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_FIT,
		S_MARK,
		S_FREE,
		S_DIRWR,
		S_RESP
	} state_t;

endpackage

### rtl/file_directory_contiguous_allocator.sv
// ----------------------------------------------------------------------------
// file_directory_contiguous_allocator
// file directory with first-fit contiguous sector allocation
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_*      in         request: operation, file_name, sector_count
//  m_*      out        result: status, start_sector, file_length
//
// one request at a time: a directory scan, then for create a sector map scan,
// marking of sector_count sectors and one directory write; delete frees its
// run at one sector a cycle.
// after reset the sector map is cleared, with s_tready low. a stalled result
// holds the block in its result state.
// ----------------------------------------------------------------------------
module file_directory_contiguous_allocator
	import fdca_pkg::*;
#(
	parameter int DIR_ENTRIES = 32,
	parameter int SECTOR_COUNT_TOTAL = 512,
	parameter int NAME_CHARS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // operation[1:0], file_name[65:2], sector_count[73:66]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[2:0], start_sector[11:3], file_length[19:12]
);
	localparam int IW = $clog2(DIR_ENTRIES);
	localparam int SW = $clog2(SECTOR_COUNT_TOTAL);
	localparam int EW = ((SW > LEN_W) ? SW : LEN_W) + 1;
	localparam logic [IW:0] NENT = (IW+1)'(DIR_ENTRIES);
	localparam logic [SW:0] NSEC = (SW+1)'(SECTOR_COUNT_TOTAL);
	localparam logic [SW-1:0] LAST_SEC = SW'(SECTOR_COUNT_TOTAL - 1);
	localparam logic [EW-1:0] NSEC_E = EW'(SECTOR_COUNT_TOTAL);

	function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] res;
		logic stop;
		res = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i < NAME_CHARS && !stop) begin
				if (raw[8*i +: 8] == 8'h00) stop = 1'b1;
				else res[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return res;
	endfunction

	state_t state_q, state_d;

	logic [1:0]        op_q;
	logic [NAME_W-1:0] name_q;
	logic [LEN_W-1:0]  count_q;

	// directory scan
	logic [IW:0]    rd_q;
	logic           dv_s1;
	logic [IW-1:0]  di_s1;
	logic           hit_q, free_q;
	logic [IW-1:0]  hit_idx_q, free_idx_q;
	logic [SW-1:0]  hit_start_q;
	logic [LEN_W-1:0] hit_len_q;

	// sector scan
	logic [SW:0]      iss_q;
	logic             mv_s1;
	logic [SW-1:0]    ms_s1;
	logic [LEN_W-1:0] run_q;
	logic [SW-1:0]    rs_q;
	logic             fit_end_q, fit_ok_q;

	// mark / free walk
	logic [EW-1:0]    wk_q;
	logic [EW-1:0]    wk_end_q;
	logic [LEN_W-1:0] left_q;

	logic [2:0]       res_status_q;
	logic [SW-1:0]    res_start_q;
	logic [LEN_W-1:0] res_len_q;
	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;

	// memory ports
	logic [IW-1:0]     dir_rd_addr;
	logic [NAME_W-1:0] dir_rd_name;
	logic [SW-1:0]     dir_rd_start;
	logic [LEN_W-1:0]  dir_rd_len;
	logic              dir_we;
	logic [IW-1:0]     dir_wa;
	logic [NAME_W-1:0] dir_wname;
	logic [SW-1:0]     dir_wstart;
	logic [LEN_W-1:0]  dir_wlen;
	logic              clearing;
	logic [SW-1:0]     map_rd_addr;
	logic              map_rd_busy;
	logic              map_we;
	logic [SW-1:0]     map_wa;
	logic              map_wd;

	logic scan_done, accept, out_free;
	logic [SW+OUT_START_W-1:0] start_wide;

	fdca_dir_mem #(.DIR_ENTRIES(DIR_ENTRIES), .SW(SW)) u_dir (
		.clk(clk), .arst_n(arst_n),
		.rd_addr(dir_rd_addr), .rd_name(dir_rd_name), .rd_start(dir_rd_start),
		.rd_len(dir_rd_len), .wr_en(dir_we), .wr_addr(dir_wa), .wr_name(dir_wname),
		.wr_start(dir_wstart), .wr_len(dir_wlen)
	);

	fdca_map_mem #(.SECTOR_COUNT_TOTAL(SECTOR_COUNT_TOTAL)) u_map (
		.clk(clk), .arst_n(arst_n), .clearing(clearing),
		.rd_addr(map_rd_addr), .rd_busy(map_rd_busy),
		.wr_en(map_we), .wr_addr(map_wa), .wr_busy(map_wd)
	);

	assign accept = s_tvalid && s_tready;
	assign scan_done = (rd_q == NENT) && !dv_s1;
	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept) state_d = S_SCAN;
			S_SCAN:   if (scan_done) state_d = S_DECIDE;
			S_DECIDE: begin
				if (op_q == OP_CREATE) begin
					if (hit_q || !free_q) state_d = S_RESP;
					else if (count_q == '0) state_d = S_DIRWR;
					else state_d = S_FIT;
				end else if (op_q == OP_DELETE) begin
					state_d = hit_q ? S_DIRWR : S_RESP;
				end else begin
					state_d = S_RESP;
				end
			end
			S_FIT:    if (fit_end_q) state_d = fit_ok_q ? S_MARK : S_RESP;
			S_MARK:   if (left_q == LEN_W'(1)) state_d = S_DIRWR;
			S_DIRWR:  state_d = (op_q == OP_DELETE) ? S_FREE : S_RESP;
			S_FREE:   if (wk_q >= wk_end_q || wk_q >= NSEC_E) state_d = S_RESP;
			S_RESP:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		s_tready    = (state_q == S_IDLE) && !clearing;
		dir_rd_addr = rd_q[IW-1:0];
		map_rd_addr = iss_q[SW-1:0];
		dir_we      = 1'b0;
		dir_wa      = hit_idx_q;
		dir_wname   = '0;
		dir_wstart  = '0;
		dir_wlen    = '0;
		map_we      = 1'b0;
		map_wa      = wk_q[SW-1:0];
		map_wd      = 1'b0;
		case (state_q)
			S_DIRWR: begin
				dir_we = 1'b1;
				if (op_q == OP_CREATE) begin
					dir_wa     = free_idx_q;
					dir_wname  = name_q;
					dir_wstart = res_start_q;
					dir_wlen   = res_len_q;
				end
			end
			S_MARK: begin
				map_we = 1'b1;
				map_wd = 1'b1;
			end
			S_FREE: begin
				map_we = (wk_q < wk_end_q) && (wk_q < NSEC_E);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			dv_s1      <= 1'b0;
			mv_s1      <= 1'b0;
			rd_q       <= '0;
			iss_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			fit_end_q  <= 1'b0;
			fit_ok_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result loads when the old one is gone or leaves this cycle
			m_tvalid_q <= ((state_q == S_RESP) && out_free) || (m_tvalid_q && !m_tready);
			dv_s1 <= (state_q == S_SCAN) && (rd_q != NENT);
			mv_s1 <= (state_q == S_FIT) && (iss_q != NSEC) && !fit_end_q;
			case (state_q)
				S_IDLE: begin
					rd_q      <= '0;
					iss_q     <= '0;
					hit_q     <= 1'b0;
					free_q    <= 1'b0;
					fit_end_q <= 1'b0;
					fit_ok_q  <= 1'b0;
				end
				S_SCAN: begin
					if (rd_q != NENT) rd_q <= rd_q + 1'b1;
					if (dv_s1) begin
						if (!hit_q && name_q != '0 && dir_rd_name == name_q) hit_q <= 1'b1;
						if (!free_q && dir_rd_name == '0) free_q <= 1'b1;
					end
				end
				S_FIT: begin
					if (iss_q != NSEC && !fit_end_q) iss_q <= iss_q + 1'b1;
					if (mv_s1 && !fit_end_q) begin
						if (!map_rd_busy && ({1'b0, run_q} + 1'b1) == {1'b0, count_q}) begin
							fit_end_q <= 1'b1;
							fit_ok_q  <= 1'b1;
						end else if (ms_s1 == LAST_SEC) begin
							fit_end_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign start_wide = {{OUT_START_W{1'b0}}, res_start_q};

	// payload registers
	always_ff @(posedge clk) begin
		di_s1 <= rd_q[IW-1:0];
		ms_s1 <= iss_q[SW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= s_tdata[1:0];
					name_q  <= normalize(s_tdata[65:2]);
					count_q <= s_tdata[73:66];
				end
				run_q <= '0;
				rs_q  <= '0;
			end
			S_SCAN: begin
				if (dv_s1) begin
					if (!hit_q && name_q != '0 && dir_rd_name == name_q) begin
						hit_idx_q   <= di_s1;
						hit_start_q <= dir_rd_start;
						hit_len_q   <= dir_rd_len;
					end
					if (!free_q && dir_rd_name == '0) free_idx_q <= di_s1;
				end
			end
			S_DECIDE: begin
				if (op_q == OP_CREATE) begin
					res_start_q <= '0;
					res_len_q   <= '0;
					if (hit_q) res_status_q <= ST_EXISTS;
					else if (!free_q) res_status_q <= ST_NO_ENTRY;
					else res_status_q <= ST_OK;
				end else if (!hit_q) begin
					res_status_q <= ST_NOT_FOUND;
					res_start_q  <= '0;
					res_len_q    <= '0;
				end else begin
					res_status_q <= ST_OK;
					res_start_q  <= hit_start_q;
					res_len_q    <= hit_len_q;
				end
				wk_q     <= EW'(hit_start_q);
				wk_end_q <= EW'(hit_start_q) + EW'(hit_len_q);
			end
			S_FIT: begin
				if (mv_s1 && !fit_end_q) begin
					if (!map_rd_busy) begin
						run_q <= run_q + 1'b1;
						if (run_q == '0) rs_q <= ms_s1;
					end else begin
						run_q <= '0;
					end
				end
				if (fit_end_q) begin
					if (fit_ok_q) begin
						res_start_q <= rs_q;
						res_len_q   <= count_q;
					end else begin
						res_status_q <= ST_DISK_FULL;
					end
					wk_q   <= EW'(rs_q);
					left_q <= count_q;
				end
			end
			S_MARK: begin
				wk_q   <= wk_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			S_FREE: begin
				wk_q <= wk_q + 1'b1;
			end
			S_RESP: begin
				if (out_free) m_tdata_q <= {4'b0, res_len_q, start_wide[OUT_START_W-1:0],
					res_status_q};
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule

### rtl/fdca_dir_mem.sv
// ----------------------------------------------------------------------------
// fdca_dir_mem
// directory store: name, start and length per entry, one read and one write
// port, registered read, per-entry valid bits cleared at reset
// ----------------------------------------------------------------------------
module fdca_dir_mem
	import fdca_pkg::*;
#(
	parameter int DIR_ENTRIES = 32,
	parameter int SW = 9
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(DIR_ENTRIES)-1:0] rd_addr,
	output logic [NAME_W-1:0]              rd_name,
	output logic [SW-1:0]                  rd_start,
	output logic [LEN_W-1:0]               rd_len,
	input  logic                           wr_en,
	input  logic [$clog2(DIR_ENTRIES)-1:0] wr_addr,
	input  logic [NAME_W-1:0]              wr_name,
	input  logic [SW-1:0]                  wr_start,
	input  logic [LEN_W-1:0]               wr_len
);
	logic [NAME_W-1:0] name_mem [DIR_ENTRIES];
	logic [SW-1:0]     start_mem [DIR_ENTRIES];
	logic [LEN_W-1:0]  len_mem [DIR_ENTRIES];
	logic [DIR_ENTRIES-1:0] vld_q;
	logic vld_s1;
	logic [NAME_W-1:0] name_s1;
	logic [SW-1:0]     start_s1;
	logic [LEN_W-1:0]  len_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			name_mem[wr_addr]  <= wr_name;
			start_mem[wr_addr] <= wr_start;
			len_mem[wr_addr]   <= wr_len;
		end
		name_s1  <= name_mem[rd_addr];
		start_s1 <= start_mem[rd_addr];
		len_s1   <= len_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			vld_s1 <= vld_q[rd_addr];
		end
	end

	// an entry never written reads as free
	assign rd_name  = vld_s1 ? name_s1 : '0;
	assign rd_start = vld_s1 ? start_s1 : '0;
	assign rd_len   = vld_s1 ? len_s1 : '0;
endmodule

### rtl/fdca_map_mem.sv
// ----------------------------------------------------------------------------
// fdca_map_mem
// sector busy map: one bit per sector, registered read, clearing pass after
// reset
// ----------------------------------------------------------------------------
module fdca_map_mem #(
	parameter int SECTOR_COUNT_TOTAL = 512
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	output logic                                  clearing,
	input  logic [$clog2(SECTOR_COUNT_TOTAL)-1:0] rd_addr,
	output logic                                  rd_busy,
	input  logic                                  wr_en,
	input  logic [$clog2(SECTOR_COUNT_TOTAL)-1:0] wr_addr,
	input  logic                                  wr_busy
);
	localparam int SW = $clog2(SECTOR_COUNT_TOTAL);
	localparam logic [SW:0] TOTAL = (SW+1)'(SECTOR_COUNT_TOTAL);

	logic mem [SECTOR_COUNT_TOTAL];
	logic [SW:0] clr_q;
	logic we;
	logic [SW-1:0] wa;
	logic wd;

	assign clearing = (clr_q != TOTAL);

	always_comb begin
		we = wr_en;
		wa = wr_addr;
		wd = wr_busy;
		if (clearing) begin
			we = 1'b1;
			wa = clr_q[SW-1:0];
			wd = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_busy <= mem[rd_addr];
	end
endmodule

### tb/sv/fdca_checker.sv
// ----------------------------------------------------------------------------
// fdca_checker
// watches both channels of the allocator, predicts each result from its own
// copy of the directory and sector map, and compares field by field
// ----------------------------------------------------------------------------
module fdca_checker
	import fdca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,  // operation[1:0], file_name[65:2], sector_count[73:66]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // status[2:0], start_sector[11:3], file_length[19:12]
	output int          fail_count,
	output int          pending
);

	localparam int ENTRIES = 32;
	localparam int SECTORS = 512;

	typedef struct packed {
		logic [7:0] file_length;
		logic [8:0] start_sector;
		logic [2:0] status;
	} alloc_result_t;

	logic [63:0] dir_name [ENTRIES];
	logic [8:0]  dir_start [ENTRIES];
	logic [7:0]  dir_len [ENTRIES];
	logic        busy [SECTORS];
	alloc_result_t result_q [$];

	assign pending = result_q.size();

	function automatic logic [63:0] norm_name(logic [63:0] raw);
		logic [63:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (raw[8*i +: 8] == 8'h00) break;
			acc[8*i +: 8] = raw[8*i +: 8];
		end
		return acc;
	endfunction

	task automatic allocate(input logic [79:0] req);
		logic [1:0] op;
		logic [63:0] nm;
		int cnt, hit, slot, run, run_start, s;
		alloc_result_t r;
		op = req[1:0];
		nm = norm_name(req[65:2]);
		cnt = req[73:66];
		hit = -1;
		slot = -1;
		r = '0;
		if (nm != 0)
			for (int i = 0; i < ENTRIES; i++)
				if (hit < 0 && dir_name[i] == nm) hit = i;
		if (op == OP_CREATE) begin
			if (hit >= 0) r.status = ST_EXISTS;
			else begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && dir_name[i] == 0) slot = i;
				if (slot < 0) r.status = ST_NO_ENTRY;
				else begin
					run = 0; run_start = 0; s = 0;
					while (run < cnt && s < SECTORS) begin
						if (!busy[s]) begin
							if (run == 0) run_start = s;
							run++;
						end else run = 0;
						s++;
					end
					if (run == cnt) begin
						for (int k = run_start; k < run_start + run; k++) busy[k] = 1'b1;
						dir_name[slot] = nm;
						dir_start[slot] = run_start;
						dir_len[slot] = cnt;
						r.start_sector = run_start;
						r.file_length = cnt;
					end else r.status = ST_DISK_FULL;
				end
			end
		end else if (op == OP_DELETE) begin
			if (hit < 0) r.status = ST_NOT_FOUND;
			else begin
				r.start_sector = dir_start[hit];
				r.file_length = dir_len[hit];
				for (int k = dir_start[hit]; k < dir_start[hit] + dir_len[hit] && k < SECTORS; k++)
					busy[k] = 1'b0;
				dir_name[hit] = '0;
				dir_start[hit] = '0;
				dir_len[hit] = '0;
			end
		end else begin
			if (hit < 0) r.status = ST_NOT_FOUND;
			else begin
				r.start_sector = dir_start[hit];
				r.file_length = dir_len[hit];
			end
		end
		result_q.push_back(r);
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			dir_name[i] = '0; dir_start[i] = '0; dir_len[i] = '0;
		end
		for (int i = 0; i < SECTORS; i++) busy[i] = 1'b0;
	end

	always @(posedge clk) begin
		alloc_result_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready) allocate(s_tdata);
			if (m_tvalid && m_tready) begin
				got = m_tdata[19:0];
				if (result_q.size() == 0) report("unexpected result", got, 0);
				else begin
					want = result_q.pop_front();
					if (got.status != want.status)
						report("status", got.status, want.status);
					if (got.start_sector != want.start_sector)
						report("start_sector", got.start_sector, want.start_sector);
					if (got.file_length != want.file_length)
						report("file_length", got.file_length, want.file_length);
				end
			end
		end
	end

endmodule

### tb/sv/tb_file_directory_contiguous_allocator.sv
// ----------------------------------------------------------------------------
// tb_file_directory_contiguous_allocator
// drives directed and random create, lookup and delete requests with random
// gaps and stalls; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_file_directory_contiguous_allocator;
	import fdca_pkg::*;

	localparam int LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;  // operation[1:0], file_name[65:2], sector_count[73:66]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // status[2:0], start_sector[11:3], file_length[19:12]
	int          fail_count, pending;
	int          cycles = 0;
	bit          long_hold = 1'b0;
	logic [63:0] names [16];

	file_directory_contiguous_allocator u_top (.*);

	fdca_checker u_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_file_directory_contiguous_allocator: FAIL");
			$finish;
		end
	end

	// receiver: random stalls per result, plus one long hold-off on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				long_hold = 1'b0;
			end
			w = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w - 1) @(negedge clk);
				@(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send(input logic [1:0] op, input logic [63:0] nm, input logic [7:0] cnt);
		int w;
		w = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) w = 0;
		repeat (w) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, cnt, nm, op};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [63:0] rand_name();
		logic [63:0] nm;
		nm = {$urandom, $urandom};
		// sometimes cut it short with a zero byte, junk beyond it
		if ($urandom_range(0, 2) == 0) nm[8*$urandom_range(0, 7) +: 8] = 8'h00;
		return nm;
	endfunction

	initial begin
		logic [1:0] op;
		logic [7:0] cnt;
		int k;
		for (int i = 0; i < 16; i++) names[i] = {32'h0, $urandom} | 64'h41;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		send(OP_LOOKUP, 64'h0, 8'h00);
		send(OP_DELETE, 64'h0, 8'h00);
		send(OP_CREATE, 64'hffff_ffff_ffff_ffff, 8'hff);
		send(OP_CREATE, 64'hffff_ffff_ffff_ffff, 8'h01);
		send(OP_LOOKUP, 64'hffff_ffff_ffff_ffff, 8'h00);
		send(OP_CREATE, 64'h0, 8'h10);
		send(OP_CREATE, 64'h42, 8'h00);
		send(OP_LOOKUP, 64'h1234_0042, 8'h00);
		send(OP_CREATE, 64'h43, 8'hff);
		send(OP_CREATE, 64'h44, 8'hff);
		send(2'd3, 64'h43, 8'h55);
		send(OP_DELETE, 64'hffff_ffff_ffff_ffff, 8'h00);
		send(OP_CREATE, 64'h45, 8'h80);
		send(OP_DELETE, 64'h42, 8'h00);
		send(OP_DELETE, 64'h43, 8'h00);
		send(OP_DELETE, 64'h45, 8'h00);
		// fill the directory for no free entry
		for (int i = 0; i < 33; i++) send(OP_CREATE, 64'h100 + i, 8'h01);
		for (int i = 0; i < 33; i++) send(OP_DELETE, 64'h100 + i, 8'h00);

		// pause until drained
		wait (pending == 0);
		long_hold = 1'b1;
		for (int i = 0; i < 500; i++) begin
			k = $urandom_range(0, 15);
			cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: op = OP_CREATE;
				4, 5: op = OP_LOOKUP;
				6, 7, 8: op = OP_DELETE;
				default: op = 2'($urandom);
			endcase
			if ($urandom_range(0, 7) == 0) send(op, rand_name(), 8'($urandom));
			else send(op, names[k], cnt);
			if (i == 250) wait (pending == 0);
		end

		wait (pending == 0);
		repeat (1200) @(posedge clk);
		if (fail_count == 0)
			$display("tb_file_directory_contiguous_allocator: PASS");
		else
			$display("tb_file_directory_contiguous_allocator: FAIL");
		$finish;
	end

endmodule

### file_directory_contiguous_allocator.f
rtl/fdca_pkg.sv
rtl/fdca_dir_mem.sv
rtl/fdca_map_mem.sv
rtl/file_directory_contiguous_allocator.sv
tb/sv/fdca_checker.sv
tb/sv/tb_file_directory_contiguous_allocator.sv
